// File: rtl/core/fdc_pkg.sv
package fdc_pkg;

	localparam int PIDX_W  = 6;   // point_index field
	localparam int CNT_F_W = 7;   // point count as seen by the controller
	localparam int LABEL_W = 7;   // cluster_label field
	localparam int LVL_W   = 7;   // membership level numerator
	localparam int CFG_W   = 7;   // min_pts_low / min_pts_high
	localparam int EPS_W   = 35;  // eps_squared
	localparam int IN_W    = 32;  // s_tdata
	localparam int OUT_W   = 16;  // m_tdata
	localparam int CFGI_W  = 2;   // cfg_index
	localparam int CFGD_W  = 35;  // cfg_data

	localparam logic [LABEL_W-1:0] NOISE = '1;

	localparam logic [CFGI_W-1:0] REG_EPS     = 2'd0;
	localparam logic [CFGI_W-1:0] REG_MIN_LOW = 2'd1;
	localparam logic [CFGI_W-1:0] REG_MIN_HI  = 2'd2;

	typedef enum logic [3:0] {
		S_LOAD, S_OUTER, S_CTR_LD, S_SCAN, S_DRAIN, S_POP, S_POP_RD, S_QTEST,
		S_BSCAN, S_UPD_RD, S_UPD_WR, S_EMIT_RD, S_EMIT_LD
	} state_t;

	typedef enum logic [1:0] {
		PH_OUTER, PH_SEED, PH_GROW, PH_BORDER
	} phase_t;

	typedef enum logic [1:0] {
		M_COUNT, M_PUSH, M_BORDER
	} mode_t;

	typedef struct packed {
		logic              load;
		logic              clear_all;
		logic [PIDX_W-1:0] addr;
		logic              ctr_load;
		logic              scan_v;
		mode_t             mode;
		logic              pop;
		logic              new_cluster;
		logic              mark_core;
		logic              mark_border;
		logic              set_blevel;
		logic              upd_wr;
		logic              out_load;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic [CNT_F_W-1:0] count;
		logic               vis;
		logic               bord;
		logic               busy;
		logic               sp_zero;
		logic [PIDX_W-1:0]  stk_q;
		logic               seed_ok;
		logic               out_free;
	} stat_t;

	// Membership numerator for a neighbor count n.
	function automatic logic [LVL_W-1:0] level_of(input logic [CFG_W-1:0] n,
			input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] d;
		d = (hi > lo) ? (hi - lo) : CFG_W'(1);
		if (n >= hi)
			return LVL_W'(d);
		else if (n <= lo)
			return '0;
		else
			return LVL_W'(n - lo);
	endfunction

endpackage

// File: rtl/core/fdc_datapath.sv
module fdc_datapath #(
	parameter int MAX_POINTS  = 64,
	parameter int COORD_BITS  = 16,
	parameter int STACK_DEPTH = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fdc_pkg::cmd_t               cmd,
	output fdc_pkg::stat_t              stat,
	input  logic [fdc_pkg::IN_W-1:0]    in_data,
	input  logic [fdc_pkg::EPS_W-1:0]   eps,
	input  logic [fdc_pkg::CFG_W-1:0]   min_lo,
	input  logic [fdc_pkg::CFG_W-1:0]   min_hi,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fdc_pkg::PIDX_W-1:0]  out_index,
	output logic [fdc_pkg::LABEL_W-1:0] out_label,
	output logic                        out_last
);
	import fdc_pkg::*;

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SA_W  = $clog2(STACK_DEPTH);
	localparam int SP_W  = $clog2(STACK_DEPTH + 1);
	localparam int CW    = COORD_BITS;
	localparam int DW    = COORD_BITS + 1;
	localparam int SQ_W  = 2 * DW;
	localparam int BM_W  = LVL_W + LABEL_W;

	logic [2*CW-1:0]  pmem [MAX_POINTS];
	logic [IDX_W-1:0] smem [STACK_DEPTH];
	logic [LVL_W-1:0] lmem [MAX_POINTS];
	logic [BM_W-1:0]  bmem [MAX_POINTS];

	logic [2*CW-1:0]  pt_rd_q;
	logic [IDX_W-1:0] stk_rd_q;
	logic [LVL_W-1:0] lvl_rd_q;
	logic [BM_W-1:0]  best_rd_q;

	logic [CNT_W-1:0] count_q;
	logic [SP_W-1:0]  sp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             found_q;
	logic [LVL_W-1:0] bmax_q;
	logic [LABEL_W-1:0] cc_q;
	logic [MAX_POINTS-1:0] vis_q, core_q, bord_q, lset_q, bset_q;
	logic signed [DW-1:0] cx_q, cy_q;

	logic             v_s1, v_s2;
	logic [IDX_W-1:0] j_s1, j_s2;
	logic [LVL_W-1:0] lvl_s2;
	logic [SQ_W-1:0]  sqx_s2, sqy_s2;

	logic out_v_q;
	logic [PIDX_W-1:0]  out_idx_q;
	logic [LABEL_W-1:0] out_lab_q;
	logic               out_last_q;

	logic [IDX_W-1:0] a;
	logic signed [DW-1:0] px, py, dx, dy;
	logic signed [SQ_W-1:0] sqx_c, sqy_c;
	logic [SQ_W:0] d2;
	logic hit, store_ok, push_ok, upd_ok;
	logic [LVL_W-1:0] new_lvl;

	assign a     = cmd.addr[IDX_W-1:0];
	assign px    = {pt_rd_q[CW-1], pt_rd_q[CW-1:0]};
	assign py    = {pt_rd_q[2*CW-1], pt_rd_q[2*CW-1:CW]};
	assign dx    = px - cx_q;
	assign dy    = py - cy_q;
	assign sqx_c = dx * dx;
	assign sqy_c = dy * dy;
	assign d2    = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign hit   = v_s2 && (EPS_W'(d2) <= eps);
	assign store_ok = cmd.load && (count_q < CNT_W'(MAX_POINTS));
	assign push_ok  = hit && (cmd.mode == M_PUSH) && (sp_q < SP_W'(STACK_DEPTH));
	assign upd_ok   = lset_q[a] && (!bset_q[a] || (lvl_rd_q > best_rd_q[BM_W-1:LABEL_W]));
	assign new_lvl  = cmd.mark_core ? level_of(CFG_W'(cnt_q), min_lo, min_hi) : bmax_q;

	// memories
	always_ff @(posedge clk) begin
		if (store_ok)
			pmem[count_q[IDX_W-1:0]] <= {in_data[16+CW-1:16], in_data[CW-1:0]};
		pt_rd_q <= pmem[a];
	end

	always_ff @(posedge clk) begin
		if (push_ok)
			smem[sp_q[SA_W-1:0]] <= j_s2;
		stk_rd_q <= smem[SA_W'(sp_q - SP_W'(1))];
	end

	always_ff @(posedge clk) begin
		if (cmd.mark_core || cmd.set_blevel)
			lmem[a] <= new_lvl;
		lvl_rd_q <= lmem[a];
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_wr && upd_ok)
			bmem[a] <= {lvl_rd_q, cc_q};
		best_rd_q <= bmem[a];
	end

	// distance pipeline payload
	always_ff @(posedge clk) begin
		j_s1   <= a;
		j_s2   <= j_s1;
		lvl_s2 <= lvl_rd_q;
		sqx_s2 <= unsigned'(sqx_c);
		sqy_s2 <= unsigned'(sqy_c);
		if (cmd.ctr_load) begin
			cx_q <= px;
			cy_q <= py;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_v;
			v_s2 <= v_s1;
		end
	end

	// accumulators and stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
			bmax_q  <= '0;
			sp_q    <= '0;
		end else begin
			if (cmd.ctr_load) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
				bmax_q  <= '0;
			end else if (hit) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cmd.mode == M_BORDER && core_q[j_s2] && lset_q[j_s2]) begin
					if (!found_q || lvl_s2 > bmax_q)
						bmax_q <= lvl_s2;
					found_q <= 1'b1;
				end
			end
			if (cmd.new_cluster)
				sp_q <= '0;
			else if (push_ok)
				sp_q <= sp_q + SP_W'(1);
			else if (cmd.pop)
				sp_q <= sp_q - SP_W'(1);
		end
	end

	// flags, point count, cluster counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cc_q    <= '1;
			vis_q   <= '0;
			core_q  <= '0;
			bord_q  <= '0;
			lset_q  <= '0;
			bset_q  <= '0;
		end else if (cmd.clear_all) begin
			count_q <= '0;
			cc_q    <= '1;
			vis_q   <= '0;
			core_q  <= '0;
			bord_q  <= '0;
			lset_q  <= '0;
			bset_q  <= '0;
		end else begin
			if (store_ok)
				count_q <= count_q + CNT_W'(1);
			if (cmd.new_cluster) begin
				core_q <= '0;
				bord_q <= '0;
				lset_q <= '0;
				cc_q   <= cc_q + LABEL_W'(1);
			end
			if (cmd.mark_core) begin
				vis_q[a]  <= 1'b1;
				core_q[a] <= 1'b1;
				lset_q[a] <= 1'b1;
			end
			if (cmd.mark_border)
				bord_q[a] <= 1'b1;
			if (cmd.set_blevel)
				lset_q[a] <= found_q;
			if (cmd.upd_wr && upd_ok)
				bset_q[a] <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (cmd.out_load)
			out_v_q <= 1'b1;
		else if (out_ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_idx_q  <= cmd.addr;
			out_lab_q  <= bset_q[a] ? best_rd_q[LABEL_W-1:0] : NOISE;
			out_last_q <= cmd.last;
		end
	end

	assign out_valid = out_v_q;
	assign out_index = out_idx_q;
	assign out_label = out_lab_q;
	assign out_last  = out_last_q;

	always_comb begin
		stat          = '0;
		stat.count    = CNT_F_W'(count_q);
		stat.vis      = vis_q[a];
		stat.bord     = bord_q[a];
		stat.busy     = v_s1 || v_s2;
		stat.sp_zero  = (sp_q == '0);
		stat.stk_q    = PIDX_W'(stk_rd_q);
		stat.seed_ok  = CFG_W'(cnt_q) > min_lo;
		stat.out_free = !out_v_q || out_ready;
	end

`ifndef SYNTHESIS
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH)) else $error("stack pointer past depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> sp_q != '0) else $error("pop on empty stack");
	a_pop_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !v_s2) else $error("pop during neighbor scan");
	a_load_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_v_q || out_ready) else $error("label overwritten");
`endif

endmodule

// File: rtl/core/fdc_ctrl.sv
module fdc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_last,
	output logic           in_ready,
	input  fdc_pkg::stat_t stat,
	output fdc_pkg::cmd_t  cmd
);
	import fdc_pkg::*;

	state_t state_q, state_d;
	phase_t ph_q, ph_d;
	logic [CNT_F_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic [PIDX_W-1:0]  q_q, q_d;
	logic q_in;

	assign q_in = {1'b0, q_q} < stat.count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			ph_q    <= PH_OUTER;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			q_q     <= '0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			q_q     <= q_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		q_d     = q_q;
		case (state_q)
			S_LOAD: begin
				if (in_valid && in_last) begin
					i_d     = '0;
					state_d = S_OUTER;
				end
			end
			S_OUTER: begin
				if (i_q == stat.count) begin
					k_d     = '0;
					state_d = S_EMIT_RD;
				end else if (stat.vis) begin
					i_d = i_q + CNT_F_W'(1);
				end else begin
					ph_d    = PH_OUTER;
					state_d = S_CTR_LD;
				end
			end
			S_CTR_LD: begin
				j_d     = '0;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				j_d = j_q + CNT_F_W'(1);
				if (j_q + CNT_F_W'(1) == stat.count)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!stat.busy) begin
					case (ph_q)
						PH_OUTER: begin
							if (stat.seed_ok) begin
								ph_d    = PH_SEED;
								state_d = S_CTR_LD;
							end else begin
								i_d     = i_q + CNT_F_W'(1);
								state_d = S_OUTER;
							end
						end
						PH_BORDER: begin
							k_d     = k_q + CNT_F_W'(1);
							state_d = S_BSCAN;
						end
						default: state_d = S_POP;
					endcase
				end
			end
			S_POP: begin
				if (stat.sp_zero) begin
					k_d     = '0;
					state_d = S_BSCAN;
				end else begin
					state_d = S_POP_RD;
				end
			end
			S_POP_RD: begin
				q_d     = stat.stk_q;
				state_d = S_QTEST;
			end
			S_QTEST: begin
				if (q_in && !stat.vis && !stat.bord) begin
					ph_d    = PH_GROW;
					state_d = S_CTR_LD;
				end else begin
					state_d = S_POP;
				end
			end
			S_BSCAN: begin
				if (k_q == stat.count) begin
					k_d     = '0;
					state_d = S_UPD_RD;
				end else if (stat.bord) begin
					ph_d    = PH_BORDER;
					state_d = S_CTR_LD;
				end else begin
					k_d = k_q + CNT_F_W'(1);
				end
			end
			S_UPD_RD: begin
				if (k_q == stat.count) begin
					i_d     = i_q + CNT_F_W'(1);
					state_d = S_OUTER;
				end else begin
					state_d = S_UPD_WR;
				end
			end
			S_UPD_WR: begin
				k_d     = k_q + CNT_F_W'(1);
				state_d = S_UPD_RD;
			end
			S_EMIT_RD: begin
				if (k_q == stat.count)
					state_d = S_LOAD;
				else
					state_d = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				if (stat.out_free) begin
					k_d     = k_q + CNT_F_W'(1);
					state_d = S_EMIT_RD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (ph_q)
			PH_OUTER:  cmd.mode = M_COUNT;
			PH_BORDER: cmd.mode = M_BORDER;
			default:   cmd.mode = M_PUSH;
		endcase
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_OUTER: cmd.addr = i_q[PIDX_W-1:0];
			S_CTR_LD: cmd.ctr_load = 1'b1;
			S_SCAN: begin
				cmd.addr   = j_q[PIDX_W-1:0];
				cmd.scan_v = 1'b1;
			end
			S_DRAIN: begin
				if (!stat.busy) begin
					case (ph_q)
						PH_OUTER: begin
							cmd.addr = i_q[PIDX_W-1:0];
							if (stat.seed_ok) begin
								cmd.new_cluster = 1'b1;
								cmd.mark_core   = 1'b1;
							end
						end
						PH_GROW: begin
							cmd.addr      = q_q;
							cmd.mark_core = 1'b1;
						end
						PH_BORDER: begin
							cmd.addr       = k_q[PIDX_W-1:0];
							cmd.set_blevel = 1'b1;
						end
						default: cmd.addr = '0;
					endcase
				end
			end
			S_POP: cmd.pop = !stat.sp_zero;
			S_QTEST: begin
				cmd.addr        = q_q;
				cmd.mark_border = q_in && (stat.vis || stat.bord);
			end
			S_BSCAN:  cmd.addr = k_q[PIDX_W-1:0];
			S_UPD_RD: cmd.addr = k_q[PIDX_W-1:0];
			S_UPD_WR: begin
				cmd.addr   = k_q[PIDX_W-1:0];
				cmd.upd_wr = 1'b1;
			end
			S_EMIT_RD: begin
				cmd.addr      = k_q[PIDX_W-1:0];
				cmd.clear_all = (k_q == stat.count);
			end
			S_EMIT_LD: begin
				cmd.addr     = k_q[PIDX_W-1:0];
				cmd.out_load = stat.out_free;
				cmd.last     = (k_q + CNT_F_W'(1) == stat.count);
			end
			default: cmd.addr = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> j_q < stat.count) else $error("scan past point count");
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT_LD |-> k_q < stat.count) else $error("label past point count");
	a_drain_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_DRAIN) |-> $past(state_q) == S_SCAN)
		else $error("drain without scan");
`endif

endmodule

// File: rtl/core/fuzzy_density_clustering.sv
// Fuzzy core DBSCAN over up to MAX_POINTS two-dimensional points. Points stream in on the
// slave side, one item each, and are stored in load order (points beyond MAX_POINTS are
// dropped); the item with tlast set closes the data set and starts clustering, and s_tready
// stays low from then until the last label has been handed to the output register. One
// label item per point leaves on the master side in index order, tlast on the last one, and
// the block returns to loading with all data-set state cleared and the registers kept. Two
// points are neighbors when their squared distance is at most eps_squared. Every
// neighborhood is found by rescanning the point memory through a two-stage squaring
// pipeline, one point per cycle; a data set costs one scan per unvisited point tested as
// a seed, a second one per seed, one per expanded point and one per border point, plus the
// stack pops, the border sweep and the level merge of each cluster, and the label output,
// which also waits while the receiver stalls. There is no clearing pass after reset.
module fuzzy_density_clustering #(
	parameter int MAX_POINTS  = 64,
	parameter int COORD_BITS  = 16,
	parameter int STACK_DEPTH = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [fdc_pkg::IN_W-1:0]    s_tdata,   // coord_x [15:0], coord_y [31:16]
	input  logic                        s_tlast,   // last_point
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [fdc_pkg::OUT_W-1:0]   m_tdata,   // point_index [5:0], cluster_label [12:6]
	output logic                        m_tlast,   // label_last
	input  logic                        cfg_we,
	input  logic [fdc_pkg::CFGI_W-1:0]  cfg_index,
	input  logic [fdc_pkg::CFGD_W-1:0]  cfg_data
);
	import fdc_pkg::*;

	logic [EPS_W-1:0] eps_q;
	logic [CFG_W-1:0] min_lo_q, min_hi_q;

	cmd_t  cmd;
	stat_t stat;
	logic [PIDX_W-1:0]  out_index;
	logic [LABEL_W-1:0] out_label;

	// configuration registers; the user must write them only between data sets, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q    <= EPS_W'(100);
			min_lo_q <= CFG_W'(2);
			min_hi_q <= CFG_W'(5);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EPS:     eps_q    <= cfg_data[EPS_W-1:0];
				REG_MIN_LOW: min_lo_q <= cfg_data[CFG_W-1:0];
				REG_MIN_HI:  min_hi_q <= cfg_data[CFG_W-1:0];
				default:     eps_q    <= eps_q;
			endcase
		end
	end

	// sequencer: outer seed loop, stack expansion, border pass, level merge, output
	fdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// point memory, distance pipeline, neighbor stack, flags and level memories
	fdc_datapath #(
		.MAX_POINTS  (MAX_POINTS),
		.COORD_BITS  (COORD_BITS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.eps       (eps_q),
		.min_lo    (min_lo_q),
		.min_hi    (min_hi_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_index (out_index),
		.out_label (out_label),
		.out_last  (m_tlast)
	);

	assign m_tdata = {3'b000, out_label, out_index};

endmodule
